// File: hw/rtl/bsts_pkg.sv
`timescale 1ns / 1ps

package bsts_pkg;

    // slot and queue sizing
    localparam int MAX_SLOTS  = 8;
    localparam int RECV_DEPTH = 8;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int RPTR_W     = $clog2(RECV_DEPTH);
    localparam int RCNT_W     = $clog2(RECV_DEPTH + 1);
    localparam int CFG_W      = 4;
    localparam int CMD_W      = 4;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TRY_RUN   = 4'd0,
        CMD_YIELD     = 4'd1,
        CMD_TRY_RECV  = 4'd2,
        CMD_PUSH_RECV = 4'd3,
        CMD_STANDBY   = 4'd4,
        CMD_NOT_READY = 4'd5,
        CMD_FINISH    = 4'd6,
        CMD_CHECK_FIN = 4'd7,
        CMD_RELEASE   = 4'd8
    } t_cmd;

    // slot status codes
    typedef enum logic [1:0] {
        ST_NOTREADY = 2'd0,
        ST_STANDBY  = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_FINISHED = 2'd3
    } t_stat;

    // classified command handed from front to back
    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot;
        logic              oob;
    } t_op;

    // result item
    typedef struct packed {
        logic              granted;
        logic              error;
        logic [SLOT_W-1:0] next_slot;
        logic              next_valid;
        t_stat             slot_state;
    } t_res;

    // effective slot count: zero acts as one, large values clamp
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        begin
            if (v == '0) begin
                r = CNT_W'(1);
            end else if (int'(v) > MAX_SLOTS) begin
                r = CNT_W'(MAX_SLOTS);
            end else begin
                r = CNT_W'(v);
            end
            return r;
        end
    endfunction

endpackage

// File: hw/rtl/bsts_front.sv
`timescale 1ns / 1ps

module bsts_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [bsts_pkg::CNT_W-1:0] i_slot_cnt,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [3:0]                i_command,
    input  logic [2:0]                i_slot_id,
    output logic                      o_push,
    output bsts_pkg::t_op             o_op,
    input  logic                      i_q_ready
);
    import bsts_pkg::*;

    logic r_valid;
    t_op  r_op;
    t_op  n_op;

    // free when empty or when the held item moves into the queue this cycle
    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid;
    assign o_op    = r_op;

    // classify: decode command and flag ids beyond the active count
    always_comb begin
        n_op.cmd  = t_cmd'(i_command);
        n_op.slot = SLOT_W'(i_slot_id);
        n_op.oob  = ({1'b0, i_slot_id} >= CNT_W'(i_slot_cnt));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op <= n_op;
        end
    end

endmodule

// File: hw/rtl/bsts_queue.sv
`timescale 1ns / 1ps

module bsts_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bsts_pkg::t_op i_op,
    output logic          o_ready,
    output logic          o_valid,
    output bsts_pkg::t_op o_op,
    input  logic          i_pop
);
    import bsts_pkg::*;

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              wr;
    logic              rd;

    assign o_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rptr];
    assign wr      = i_push && o_ready;
    assign rd      = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (int'(r_wptr) == QDEPTH - 1) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (rd) begin
                r_rptr <= (int'(r_rptr) == QDEPTH - 1) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_op;
        end
    end

endmodule

// File: hw/rtl/bsts_back.sv
`timescale 1ns / 1ps

module bsts_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bsts_pkg::CNT_W-1:0] i_slot_cnt,
    input  logic                       i_q_valid,
    input  bsts_pkg::t_op              i_op,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output bsts_pkg::t_res             o_res
);
    import bsts_pkg::*;

    // scheduler state
    t_stat              r_stat [MAX_SLOTS];
    t_stat              n_stat [MAX_SLOTS];
    logic [SLOT_W-1:0]  r_ptr;
    logic [SLOT_W-1:0]  n_ptr;
    logic               r_ptr_valid;
    logic               n_ptr_valid;
    logic [SLOT_W-1:0]  r_fifo [RECV_DEPTH];
    logic [RPTR_W-1:0]  r_head;
    logic [RPTR_W-1:0]  n_head;
    logic [RCNT_W-1:0]  r_rcnt;
    logic [RCNT_W-1:0]  n_rcnt;
    logic               fifo_we;
    logic [RPTR_W-1:0]  fifo_waddr;

    // output register
    logic               r_out_valid;
    t_res               r_res;
    t_res               n_res;

    // scan results
    logic [MAX_SLOTS-1:0] act;
    logic [MAX_SLOTS-1:0] stby;
    logic [MAX_SLOTS-1:0] self_mask;
    logic                 running_any;
    logic                 other_stby;
    logic [CNT_W-1:0]     live_cnt;
    logic [SLOT_W:0]      yld_pick;
    logic [SLOT_W:0]      nr_pick;
    logic                 take;
    t_stat                cur;
    logic [RPTR_W:0]      waddr_sum;

    // first standby slot after s, wrapping at n, s itself checked last
    // returns {found, slot}
    function automatic logic [SLOT_W:0] pick_next(
        input logic [MAX_SLOTS-1:0] mask,
        input logic [SLOT_W-1:0]    s,
        input logic [CNT_W-1:0]     n
    );
        logic [CNT_W:0]    t;
        logic              found;
        logic [SLOT_W-1:0] idx;
        begin
            found = 1'b0;
            idx   = '0;
            for (int k = 1; k <= MAX_SLOTS; k++) begin
                t = (CNT_W+1)'(s) + (CNT_W+1)'(k);
                if (t >= (CNT_W+1)'(n)) begin
                    t = t - (CNT_W+1)'(n);
                end
                if (k <= int'(n) && !found && mask[t[SLOT_W-1:0]]) begin
                    found = 1'b1;
                    idx   = t[SLOT_W-1:0];
                end
            end
            return {found, idx};
        end
    endfunction

    assign take    = i_q_valid && (!r_out_valid || i_ready);
    assign o_pop   = take;
    assign o_valid = r_out_valid;
    assign o_res   = r_res;
    assign cur     = r_stat[i_op.slot];

    // status scan over the active slots
    always_comb begin
        running_any = 1'b0;
        live_cnt    = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            act[i]       = (CNT_W'(i) < i_slot_cnt);
            stby[i]      = act[i] && (r_stat[i] == ST_STANDBY);
            self_mask[i] = (SLOT_W'(i) == i_op.slot);
            if (act[i] && r_stat[i] == ST_RUNNING) begin
                running_any = 1'b1;
            end
            if (act[i] && r_stat[i] != ST_NOTREADY) begin
                live_cnt = live_cnt + CNT_W'(1);
            end
        end
        other_stby = |(stby & ~self_mask);
        yld_pick   = pick_next(stby, i_op.slot, i_slot_cnt);
        nr_pick    = pick_next(stby & ~self_mask, i_op.slot, i_slot_cnt);
    end

    // receive queue write slot
    always_comb begin
        waddr_sum = (RPTR_W+1)'(r_head) + (RPTR_W+1)'(r_rcnt);
        if (waddr_sum >= (RPTR_W+1)'(RECV_DEPTH)) begin
            waddr_sum = waddr_sum - (RPTR_W+1)'(RECV_DEPTH);
        end
        fifo_waddr = waddr_sum[RPTR_W-1:0];
    end

    // command execution
    always_comb begin
        n_stat      = r_stat;
        n_ptr       = r_ptr;
        n_ptr_valid = r_ptr_valid;
        n_head      = r_head;
        n_rcnt      = r_rcnt;
        fifo_we     = 1'b0;
        n_res       = '0;
        if (i_op.oob) begin
            n_res.error = 1'b1;
        end else begin
            unique case (i_op.cmd) inside
                CMD_TRY_RUN: begin
                    if (cur == ST_RUNNING) begin
                        n_res.granted = 1'b1;
                    end else if (!running_any && cur == ST_STANDBY &&
                                 (!r_ptr_valid || r_ptr == i_op.slot)) begin
                        n_stat[i_op.slot] = ST_RUNNING;
                        n_ptr             = i_op.slot;
                        n_ptr_valid       = 1'b1;
                        n_res.granted     = 1'b1;
                    end
                end
                CMD_YIELD: begin
                    if (other_stby && cur == ST_RUNNING) begin
                        n_ptr_valid       = yld_pick[SLOT_W];
                        n_ptr             = yld_pick[SLOT_W-1:0];
                        n_stat[i_op.slot] = ST_STANDBY;
                        n_res.granted     = 1'b1;
                    end
                end
                CMD_TRY_RECV: begin
                    if (cur == ST_RUNNING) begin
                        n_res.granted = 1'b1;
                    end else if (r_rcnt > RCNT_W'(1)) begin
                        n_res.granted = (r_fifo[r_head] == i_op.slot);
                    end else begin
                        n_res.granted = (live_cnt <= CNT_W'(1));
                    end
                    if (n_res.granted && r_rcnt != '0) begin
                        n_head = (int'(r_head) == RECV_DEPTH - 1) ? '0
                                                                 : r_head + RPTR_W'(1);
                        n_rcnt = r_rcnt - RCNT_W'(1);
                    end
                end
                CMD_PUSH_RECV: begin
                    if (r_rcnt == RCNT_W'(RECV_DEPTH)) begin
                        n_res.error = 1'b1;
                    end else begin
                        fifo_we       = 1'b1;
                        n_rcnt        = r_rcnt + RCNT_W'(1);
                        n_res.granted = 1'b1;
                    end
                end
                CMD_STANDBY: begin
                    if (cur != ST_RUNNING) begin
                        n_stat[i_op.slot] = ST_STANDBY;
                        n_res.granted     = 1'b1;
                    end
                end
                CMD_NOT_READY, CMD_RELEASE: begin
                    // release never yields: the slot is not running
                    if (i_op.cmd == CMD_NOT_READY || cur == ST_FINISHED ||
                        cur == ST_NOTREADY) begin
                        n_stat[i_op.slot] = ST_NOTREADY;
                        if (r_ptr_valid && r_ptr == i_op.slot) begin
                            n_ptr_valid = nr_pick[SLOT_W];
                            n_ptr       = nr_pick[SLOT_W-1:0];
                        end
                        n_res.granted = 1'b1;
                    end
                end
                CMD_FINISH: begin
                    n_stat[i_op.slot] = ST_FINISHED;
                    n_res.granted     = 1'b1;
                end
                CMD_CHECK_FIN: begin
                    n_res.granted = (cur == ST_FINISHED || cur == ST_NOTREADY);
                end
                default: begin
                end
            endcase
            n_res.slot_state = n_stat[i_op.slot];
        end
        n_res.next_valid = n_ptr_valid;
        n_res.next_slot  = n_ptr_valid ? n_ptr : '0;
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_stat[i] <= ST_NOTREADY;
            end
            r_ptr       <= '0;
            r_ptr_valid <= 1'b0;
            r_head      <= '0;
            r_rcnt      <= '0;
        end else if (take) begin
            r_stat      <= n_stat;
            r_ptr       <= n_ptr;
            r_ptr_valid <= n_ptr_valid;
            r_head      <= n_head;
            r_rcnt      <= n_rcnt;
        end
    end

    // receive queue storage
    always_ff @(posedge i_clk) begin
        if (take && fifo_we) begin
            r_fifo[fifo_waddr] <= i_op.slot;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

`ifndef SYNTH
    // an error result never grants
    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.error && r_res.granted))
        else $error("error and granted both set");

    // an empty pointer reads as slot zero
    a_ptr_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.next_valid) |-> (r_res.next_slot == '0))
        else $error("empty pointer with nonzero slot");

    // receive count stays within the queue depth
    a_rcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= RCNT_W'(RECV_DEPTH))
        else $error("receive count overflow");

    // a granted run leaves the pointer on that slot
    a_run_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && n_res.granted && i_op.cmd == CMD_TRY_RUN)
            |=> (r_ptr_valid && r_stat[r_ptr] == ST_RUNNING))
        else $error("granted run without pointer");
`endif

endmodule

// File: hw/rtl/batch_slot_turn_scheduler.sv
`timescale 1ns / 1ps

// Batch slot turn scheduler. Each command names a slot and returns one result
// item: granted, error, the round-robin pointer after the command and the
// named slot's status. Blocking waits are try commands; the caller retries
// until granted. A front stage registers and classifies each command (id range
// check against the active slot count) and hands it through a two-entry queue
// to the execution stage, which applies the command combinationally,
// including the scan over up to eight slot statuses, and writes the result
// register. A command passes the front register, the queue and the result
// register before o_valid rises; one command per cycle is sustained while the
// result side keeps taking items. The user must write the active slot count
// through i_cfg_we / i_cfg_data only while no command is in flight; the block
// itself does not enforce this. Zero acts as one and values above eight act
// as eight.
module batch_slot_turn_scheduler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_command,
    input  logic [2:0] i_slot_id,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_granted,
    output logic       o_error,
    output logic [2:0] o_next_slot,
    output logic       o_next_valid,
    output logic [1:0] o_slot_state
);
    import bsts_pkg::*;

    logic [CFG_W-1:0] r_active_slots;
    logic [CNT_W-1:0] slot_cnt;
    logic             f_push;
    t_op              f_op;
    logic             q_ready;
    logic             q_valid;
    t_op              q_op;
    logic             b_pop;
    t_res             b_res;

    // active slot count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= CFG_W'(MAX_SLOTS);
        end else if (i_cfg_we) begin
            r_active_slots <= i_cfg_data;
        end
    end

    assign slot_cnt = clamp_count(r_active_slots);

    bsts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_slot_cnt (slot_cnt),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_slot_id  (i_slot_id),
        .o_push     (f_push),
        .o_op       (f_op),
        .i_q_ready  (q_ready)
    );

    bsts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_op    (f_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (b_pop)
    );

    bsts_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_slot_cnt (slot_cnt),
        .i_q_valid  (q_valid),
        .i_op       (q_op),
        .o_pop      (b_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (b_res)
    );

    // result fields
    assign o_granted    = b_res.granted;
    assign o_error      = b_res.error;
    assign o_next_slot  = b_res.next_slot;
    assign o_next_valid = b_res.next_valid;
    assign o_slot_state = b_res.slot_state;

endmodule

// File: dv/batch_slot_turn_scheduler_test.sv
`timescale 1ns / 1ps

module batch_slot_turn_scheduler_test;
    import bsts_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PAUSE   = 14;
    localparam int LONG_HOLD   = 80;
    localparam int FLOW_LEN    = 10;
    localparam int CMD_TOP     = (1 << CMD_W) - 1;
    localparam int SLOT_TOP    = MAX_SLOTS - 1;
    localparam int CFG_TOP     = (1 << CFG_W) - 1;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
    } t_sched_cmd;

    // dut signals
    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data   = '0;
    logic              i_valid      = 1'b0;
    logic [CMD_W-1:0]  i_command    = '0;
    logic [SLOT_W-1:0] i_slot_id    = '0;
    logic              i_ready      = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_granted;
    logic              o_error;
    logic [2:0]        o_next_slot;
    logic              o_next_valid;
    logic [1:0]        o_slot_state;

    // stimulus and scoreboard
    t_sched_cmd pending_cmds [$];
    t_res       expected_res [$];
    int         n_queued   = 0;
    int         n_accepted = 0;
    int         n_results  = 0;
    int         n_fail     = 0;
    int         cycle_cnt  = 0;
    logic       in_taken   = 1'b0;
    logic       out_taken  = 1'b0;
    bit         tx_idle    = 1'b0;
    bit         rx_idle    = 1'b0;
    int         tx_wait    = 0;
    int         rx_wait    = 0;

    // scheduler shadow state
    t_stat             slot_st [MAX_SLOTS];
    logic [SLOT_W-1:0] turn_ptr;
    logic              turn_ok;
    logic [SLOT_W-1:0] recv_ids [RECV_DEPTH];
    int                recv_cnt;
    int                recv_rd;
    logic [CFG_W-1:0]  active_cfg;

    // per-slot position in the well-formed command flow
    t_cmd flow_seq [FLOW_LEN] = '{CMD_STANDBY, CMD_TRY_RUN, CMD_PUSH_RECV, CMD_TRY_RECV,
                                  CMD_YIELD, CMD_TRY_RUN, CMD_TRY_RECV, CMD_FINISH,
                                  CMD_CHECK_FIN, CMD_RELEASE};
    int   flow_pos [MAX_SLOTS] = '{default: 0};

    batch_slot_turn_scheduler u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_slot_id    (i_slot_id),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_granted    (o_granted),
        .o_error      (o_error),
        .o_next_slot  (o_next_slot),
        .o_next_valid (o_next_valid),
        .o_slot_state (o_slot_state)
    );

    always #5 i_clk = ~i_clk;

    // slot count in effect for a register value
    function automatic int eff_slots(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_SLOTS) return MAX_SLOTS;
        return int'(v);
    endfunction

    function automatic int pause_len(input bit on);
        return on ? int'($urandom_range(0, MAX_PAUSE)) : 0;
    endfunction

    // move the turn to the first standby slot after s, s itself last
    function automatic void pass_turn(input int s, input int n);
        int c;
        c = s;
        for (int k = 0; k < n; k++) begin
            c = (c + 1 >= n) ? 0 : c + 1;
            if (slot_st[c] == ST_STANDBY) begin
                turn_ptr = SLOT_W'(c);
                turn_ok  = 1'b1;
                return;
            end
        end
        turn_ptr = '0;
        turn_ok  = 1'b0;
    endfunction

    // running slot hands its turn on if another slot stands by
    function automatic bit hand_off(input int s, input int n);
        bit other;
        other = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (i != s && slot_st[i] == ST_STANDBY) other = 1'b1;
        end
        if (other && slot_st[s] == ST_RUNNING) begin
            pass_turn(s, n);
            slot_st[s] = ST_STANDBY;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void drop_slot(input int s, input int n);
        slot_st[s] = ST_NOTREADY;
        if (turn_ok && int'(turn_ptr) == s) pass_turn(s, n);
    endfunction

    // apply one command to the shadow state and return its result item
    function automatic t_res apply_command(input logic [CMD_W-1:0] cmd,
                                           input logic [SLOT_W-1:0] slot);
        t_res r;
        int   n;
        int   s;
        int   live;
        bit   busy;
        r = '0;
        n = eff_slots(active_cfg);
        s = int'(slot);
        if (s >= n) begin
            r.error = 1'b1;
        end else begin
            case (cmd)
                CMD_TRY_RUN: begin
                    if (slot_st[s] == ST_RUNNING) begin
                        r.granted = 1'b1;
                    end else begin
                        busy = 1'b0;
                        for (int i = 0; i < n; i++) begin
                            if (slot_st[i] == ST_RUNNING) busy = 1'b1;
                        end
                        if (!busy && slot_st[s] == ST_STANDBY && (!turn_ok || turn_ptr == slot)) begin
                            slot_st[s] = ST_RUNNING;
                            turn_ptr   = slot;
                            turn_ok    = 1'b1;
                            r.granted  = 1'b1;
                        end
                    end
                end
                CMD_YIELD: begin
                    r.granted = hand_off(s, n);
                end
                CMD_TRY_RECV: begin
                    if (slot_st[s] == ST_RUNNING) begin
                        r.granted = 1'b1;
                    end else if (recv_cnt > 1) begin
                        r.granted = (recv_ids[recv_rd] == slot);
                    end else begin
                        live = 0;
                        for (int i = 0; i < n; i++) begin
                            if (slot_st[i] != ST_NOTREADY) live++;
                        end
                        r.granted = (live <= 1);
                    end
                    // an empty queue is left alone
                    if (r.granted && recv_cnt > 0) begin
                        recv_rd = (recv_rd + 1) % RECV_DEPTH;
                        recv_cnt--;
                    end
                end
                CMD_PUSH_RECV: begin
                    if (recv_cnt >= RECV_DEPTH) begin
                        r.error = 1'b1;
                    end else begin
                        recv_ids[(recv_rd + recv_cnt) % RECV_DEPTH] = slot;
                        recv_cnt++;
                        r.granted = 1'b1;
                    end
                end
                CMD_STANDBY: begin
                    if (slot_st[s] != ST_RUNNING) begin
                        slot_st[s] = ST_STANDBY;
                        r.granted  = 1'b1;
                    end
                end
                CMD_NOT_READY: begin
                    drop_slot(s, n);
                    r.granted = 1'b1;
                end
                CMD_FINISH: begin
                    slot_st[s] = ST_FINISHED;
                    r.granted  = 1'b1;
                end
                CMD_CHECK_FIN: begin
                    r.granted = (slot_st[s] == ST_FINISHED || slot_st[s] == ST_NOTREADY);
                end
                CMD_RELEASE: begin
                    if (slot_st[s] == ST_FINISHED || slot_st[s] == ST_NOTREADY) begin
                        void'(hand_off(s, n));
                        drop_slot(s, n);
                        r.granted = 1'b1;
                    end
                end
                default: ;
            endcase
            r.slot_state = slot_st[s];
        end
        r.next_valid = turn_ok;
        r.next_slot  = turn_ok ? turn_ptr : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_fail++;
        end
    endtask

    // predict on accepted commands, compare accepted results
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            foreach (slot_st[i]) slot_st[i] = ST_NOTREADY;
            turn_ptr   = '0;
            turn_ok    = 1'b0;
            recv_cnt   = 0;
            recv_rd    = 0;
            active_cfg = CFG_W'(MAX_SLOTS);
        end else begin
            if (i_cfg_we) active_cfg = i_cfg_data;
            if (o_valid && i_ready) begin
                if (expected_res.size() == 0) begin
                    $display("%0t: result item with none expected, granted %0d error %0d",
                             $time, o_granted, o_error);
                    n_fail++;
                end else begin
                    want = expected_res.pop_front();
                    check_field("granted", want.granted, o_granted);
                    check_field("error", want.error, o_error);
                    check_field("next_slot", want.next_slot, o_next_slot);
                    check_field("next_valid", want.next_valid, o_next_valid);
                    check_field("slot_state", want.slot_state, o_slot_state);
                end
                n_results <= n_results + 1;
            end
            if (i_valid && o_ready) begin
                expected_res.push_back(apply_command(i_command, i_slot_id));
                n_accepted <= n_accepted + 1;
            end
        end
        in_taken  <= i_rst_n && i_valid && o_ready;
        out_taken <= i_rst_n && o_valid && i_ready;
    end

    // command driver
    always @(negedge i_clk) begin
        t_sched_cmd nxt;
        if (i_valid && !in_taken) begin
            // hold the item until taken
        end else if (tx_wait != 0) begin
            i_valid <= 1'b0;
            tx_wait <= tx_wait - 1;
        end else if (pending_cmds.size() != 0) begin
            nxt = pending_cmds.pop_front();
            i_command <= nxt.cmd;
            i_slot_id <= nxt.slot;
            i_valid   <= 1'b1;
            tx_wait   <= pause_len(tx_idle);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result-side ready, with two long holds to back the block up
    always @(negedge i_clk) begin
        int w;
        if (out_taken) begin
            if (n_results == 90 || n_results == 330) begin
                w = LONG_HOLD;
            end else begin
                w = pause_len(rx_idle);
            end
            if (w == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                rx_wait <= w - 1;
            end
        end else if (rx_wait != 0) begin
            i_ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_cmd(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s);
        t_sched_cmd it;
        it.cmd  = c;
        it.slot = s;
        pending_cmds.push_back(it);
        n_queued++;
    endtask

    // wait until every item is accepted and every result has arrived
    task automatic wait_idle();
        do @(negedge i_clk);
        while (n_accepted != n_queued || expected_res.size() != 0);
    endtask

    task automatic set_active(input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_data <= v;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly interleaved slot flows, the rest random noise
    task automatic run_random(input int count, input logic [CFG_W-1:0] cfg);
        int n;
        int s;
        n = eff_slots(cfg);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                s = $urandom_range(0, n - 1);
                add_cmd(flow_seq[flow_pos[s]], SLOT_W'(s));
                flow_pos[s] = (flow_pos[s] + 1) % FLOW_LEN;
            end else if ($urandom_range(0, 3) == 0) begin
                add_cmd(CMD_W'($urandom_range(0, CMD_TOP)), SLOT_W'($urandom_range(0, SLOT_TOP)));
            end else begin
                add_cmd(CMD_W'($urandom_range(0, CMD_RELEASE)),
                        SLOT_W'($urandom_range(0, SLOT_TOP)));
            end
        end
        wait_idle();
    endtask

    initial begin
        logic [CFG_W-1:0] cfg;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: four active slots
        set_active(CFG_W'(4));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        add_cmd(CMD_TRY_RUN, 3'd0);
        add_cmd(CMD_STANDBY, 3'd0);
        add_cmd(CMD_STANDBY, 3'd1);
        add_cmd(CMD_TRY_RUN, 3'd1);
        add_cmd(CMD_TRY_RUN, 3'd0);
        add_cmd(CMD_YIELD, 3'd1);
        add_cmd(CMD_TRY_RUN, 3'd0);
        add_cmd(CMD_TRY_RECV, 3'd1);
        add_cmd(CMD_TRY_RECV, 3'd0);
        add_cmd(CMD_FINISH, 3'd0);
        add_cmd(CMD_CHECK_FIN, 3'd0);
        add_cmd(CMD_RELEASE, 3'd0);
        add_cmd(CMD_STANDBY, 3'd7);
        add_cmd(CMD_W'(CMD_TOP), 3'd2);
        // fill the receive queue and push once more
        for (int k = 0; k <= RECV_DEPTH; k++) add_cmd(CMD_PUSH_RECV, SLOT_W'(k % 4));
        add_cmd(CMD_TRY_RECV, 3'd3);
        add_cmd(CMD_RELEASE, 3'd1);
        wait_idle();

        // random phases over several slot counts and idle mixes
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_active(CFG_W'(8));
        run_random(80, CFG_W'(8));

        tx_idle = 1'b1;
        set_active(CFG_W'(1));
        run_random(60, CFG_W'(1));

        tx_idle = 1'b0;
        rx_idle = 1'b1;
        set_active(CFG_W'(0));
        run_random(50, CFG_W'(0));

        tx_idle = 1'b1;
        set_active(CFG_W'(CFG_TOP));
        run_random(80, CFG_W'(CFG_TOP));

        set_active(CFG_W'(5));
        run_random(70, CFG_W'(5));

        set_active(CFG_W'(3));
        run_random(60, CFG_W'(3));

        cfg = CFG_W'($urandom_range(0, CFG_TOP));
        set_active(cfg);
        run_random(50, cfg);

        // let any stray result show up
        repeat (10) @(negedge i_clk);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
